>>> hdl/tmba_pkg.sv
// ----------------------------------------------------------------------------
// tmba_pkg: shared types, constants and tables
// tanh segment table, register indexes and fixed widths of the curve parameter
// ----------------------------------------------------------------------------
package tmba_pkg;

  localparam int DEFAULT_DATA_WIDTH = 16;

  // integer bits of the Q4.F input and point format
  localparam int INT_BITS = 4;
  // segment step is 0.25, two bits below the binary point
  localparam int SEG_FRAC_DROP = 2;

  localparam int NUM_SEGS = 16;
  localparam int SEG_IDX_WIDTH = 5;    // table index 0..16
  localparam int MAG_IDX_WIDTH = 6;    // |x| / 0.25 reaches 32 for the most negative x
  localparam int T_WIDTH = 16;         // unsigned Q0.16
  localparam int DIFF_WIDTH = 15;      // largest table step is 16051

  localparam logic [T_WIDTH:0] ONE_Q16 = 17'h10000;

  localparam int CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_POINT_ZERO  = 2'd0,
    REG_POINT_ONE   = 2'd1,
    REG_POINT_TWO   = 2'd2,
    REG_POINT_THREE = 2'd3
  } cfg_reg_t;

  // tanh(k/4) in Q0.16, k = 0..16; codes past the table read the last entry
  function automatic logic [T_WIDTH-1:0] tanh_lut(input logic [SEG_IDX_WIDTH-1:0] k);
    logic [T_WIDTH-1:0] v;
    unique case (k)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd16051;
      5'd2:    v = 16'd30285;
      5'd3:    v = 16'd41625;
      5'd4:    v = 16'd49913;
      5'd5:    v = 16'd55593;
      5'd6:    v = 16'd59320;
      5'd7:    v = 16'd61694;
      5'd8:    v = 16'd63179;
      5'd9:    v = 16'd64096;
      5'd10:   v = 16'd64659;
      5'd11:   v = 16'd65003;
      5'd12:   v = 16'd65212;
      5'd13:   v = 16'd65339;
      5'd14:   v = 16'd65417;
      5'd15:   v = 16'd65464;
      default: v = 16'd65492;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/tanh_mapped_bezier_activation.sv
// ----------------------------------------------------------------------------
// tanh_mapped_bezier_activation: cubic Bezier activation on a tanh-mapped axis
// maps x to t = (tanh(x)+1)/2 and evaluates the curve over four control
// points by de Casteljau's scheme, three lerp levels deep
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+--------------------
//  input    | start, busy, x_value                      | start && !busy
//  result   | done, y_value                             | done, one cycle
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
//  one item per cycle; results come out in the order of their items
//  pipeline: table lookup, tanh interpolation, then one stage per lerp level
//  busy never rises: every stage moves each cycle and the receiver cannot stall
//  rst (synchronous) clears the valid chain and loads the default points
//  points are read live by the first lerp level: write them only while idle
//
module tanh_mapped_bezier_activation #(
  parameter int DATA_WIDTH = tmba_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // item input
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [DATA_WIDTH-1:0]         x_value,
  // result output
  output logic                                 done,
  output logic signed [DATA_WIDTH-1:0]         y_value,
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tmba_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]                cfg_data
);
  import tmba_pkg::*;

  localparam int FRAC_BITS = DATA_WIDTH - INT_BITS;

  // control points, signed Q4.F
  logic signed [DATA_WIDTH-1:0] point_zero;
  logic signed [DATA_WIDTH-1:0] point_one;
  logic signed [DATA_WIDTH-1:0] point_two;
  logic signed [DATA_WIDTH-1:0] point_three;

  // parameter stage outputs
  logic               valid2;
  logic [T_WIDTH-1:0] t2;

  // lerp levels: valid and t travel beside the data
  logic               valid3;
  logic               valid4;
  logic               valid5;
  logic [T_WIDTH-1:0] t3;
  logic [T_WIDTH-1:0] t4;

  logic signed [DATA_WIDTH-1:0] a0;
  logic signed [DATA_WIDTH-1:0] a1;
  logic signed [DATA_WIDTH-1:0] a2;
  logic signed [DATA_WIDTH-1:0] b0;
  logic signed [DATA_WIDTH-1:0] b1;

  // every cycle takes a new item
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      point_zero  <= '0;
      point_one   <= DATA_WIDTH'(1) << FRAC_BITS;
      point_two   <= DATA_WIDTH'(2) << FRAC_BITS;
      point_three <= DATA_WIDTH'(3) << FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POINT_ZERO:  point_zero  <= cfg_data;
        REG_POINT_ONE:   point_one   <= cfg_data;
        REG_POINT_TWO:   point_two   <= cfg_data;
        REG_POINT_THREE: point_three <= cfg_data;
        default: ;
      endcase
    end
  end

  // stages one and two: x to curve parameter
  tmba_param_map #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_param_map (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .x_value  (x_value),
    .out_valid(valid2),
    .t_out    (t2)
  );

  // stage three: first lerp level over the points
  tmba_lerp #(.DATA_WIDTH(DATA_WIDTH)) u_lerp_a0 (
    .clk(clk), .a(point_zero), .b(point_one), .t(t2), .y(a0)
  );
  tmba_lerp #(.DATA_WIDTH(DATA_WIDTH)) u_lerp_a1 (
    .clk(clk), .a(point_one), .b(point_two), .t(t2), .y(a1)
  );
  tmba_lerp #(.DATA_WIDTH(DATA_WIDTH)) u_lerp_a2 (
    .clk(clk), .a(point_two), .b(point_three), .t(t2), .y(a2)
  );

  // stage four: second level
  tmba_lerp #(.DATA_WIDTH(DATA_WIDTH)) u_lerp_b0 (
    .clk(clk), .a(a0), .b(a1), .t(t3), .y(b0)
  );
  tmba_lerp #(.DATA_WIDTH(DATA_WIDTH)) u_lerp_b1 (
    .clk(clk), .a(a1), .b(a2), .t(t3), .y(b1)
  );

  // stage five: final level lands straight in the output register
  tmba_lerp #(.DATA_WIDTH(DATA_WIDTH)) u_lerp_y (
    .clk(clk), .a(b0), .b(b1), .t(t4), .y(y_value)
  );

  // valid chain and parameter delay line
  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
      valid4 <= 1'b0;
      valid5 <= 1'b0;
    end else begin
      valid3 <= valid2;
      valid4 <= valid3;
      valid5 <= valid4;
    end
    t3 <= t2;
    t4 <= t3;
  end

  assign done = valid5;

  // a result always traces back to an item accepted at the pipeline input
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without a matching item");

  // mapped parameter stays strictly inside the unit interval
  a_param_range: assert property (@(posedge clk) disable iff (rst)
    valid2 |-> (t2 >= 16'd11 && t2 <= 16'd65514))
    else $error("curve parameter out of range");

  // level-two lerp results trail the parameter stage through the valid3 and valid4 registers
  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    valid4 |-> $past(valid2, 2))
    else $error("valid chain broken");

endmodule

>>> hdl/tmba_param_map.sv
// ----------------------------------------------------------------------------
// tmba_param_map: input to curve parameter
// two stages: table lookup, then interpolation and mapping t = (tanh(x)+1)/2
// ----------------------------------------------------------------------------
module tmba_param_map #(
  parameter int DATA_WIDTH = tmba_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic signed [DATA_WIDTH-1:0]     x_value,
  output logic                             out_valid,
  output logic [tmba_pkg::T_WIDTH-1:0]     t_out
);
  import tmba_pkg::*;

  localparam int SEG_SHIFT = DATA_WIDTH - INT_BITS - SEG_FRAC_DROP;

  // stage 1 combinational
  logic [DATA_WIDTH-1:0]    mag;
  logic [MAG_IDX_WIDTH-1:0] idx;
  logic                     sat;
  logic [T_WIDTH-1:0]       lo_next;
  logic [T_WIDTH-1:0]       hi_next;
  logic [T_WIDTH-1:0]       step_next;

  // stage 1 registers
  logic                     valid1;
  logic                     neg1;
  logic [T_WIDTH-1:0]       lo1;
  logic [DIFF_WIDTH-1:0]    diff1;
  logic [SEG_SHIFT-1:0]     frac1;

  // stage 2 combinational
  logic [DIFF_WIDTH+SEG_SHIFT-1:0] prod;
  logic [T_WIDTH-1:0]              th;
  logic [T_WIDTH:0]                t_sum;

  always_comb begin
    mag = x_value[DATA_WIDTH-1] ? (~x_value + 1'b1) : x_value;
    idx = mag[DATA_WIDTH-1:SEG_SHIFT];
    sat = idx[MAG_IDX_WIDTH-1] | idx[MAG_IDX_WIDTH-2];
    lo_next = tanh_lut(idx[SEG_IDX_WIDTH-1:0]);
    hi_next = tanh_lut(idx[SEG_IDX_WIDTH-1:0] + 1'b1);
    if (sat) begin
      lo_next = tanh_lut(SEG_IDX_WIDTH'(NUM_SEGS));
      hi_next = lo_next;
    end
    step_next = hi_next - lo_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_valid;
    end
    neg1  <= x_value[DATA_WIDTH-1];
    lo1   <= lo_next;
    diff1 <= step_next[DIFF_WIDTH-1:0];
    frac1 <= mag[SEG_SHIFT-1:0];
  end

  always_comb begin
    prod  = DIFF_WIDTH'(diff1) * (DIFF_WIDTH+SEG_SHIFT)'(frac1);
    th    = lo1 + T_WIDTH'(prod[DIFF_WIDTH+SEG_SHIFT-1:SEG_SHIFT]);
    t_sum = neg1 ? (ONE_Q16 - {1'b0, th}) : (ONE_Q16 + {1'b0, th});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid1;
    end
    t_out <= t_sum[T_WIDTH:1];
  end

endmodule

>>> hdl/tmba_lerp.sv
// ----------------------------------------------------------------------------
// tmba_lerp: registered linear interpolation
// y = a + floor((b - a) * t / 2^16), always between a and b
// ----------------------------------------------------------------------------
module tmba_lerp #(
  parameter int DATA_WIDTH = tmba_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  input  logic [tmba_pkg::T_WIDTH-1:0] t,
  output logic signed [DATA_WIDTH-1:0] y
);
  import tmba_pkg::*;

  logic signed [DATA_WIDTH:0]           diff;
  logic signed [DATA_WIDTH+T_WIDTH+1:0] prod;
  logic signed [DATA_WIDTH+1:0]         step;
  logic signed [DATA_WIDTH+1:0]         sum;

  always_comb begin
    diff = {b[DATA_WIDTH-1], b} - {a[DATA_WIDTH-1], a};
    prod = diff * $signed({1'b0, t});
    // dropping the low bits of a signed product is a floor
    step = prod[DATA_WIDTH+T_WIDTH+1:T_WIDTH];
    sum  = {{2{a[DATA_WIDTH-1]}}, a} + step;
  end

  always_ff @(posedge clk) begin
    y <= sum[DATA_WIDTH-1:0];
  end

endmodule

>>> bench/tmba_curve_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmba_curve_checker: result checker for the tanh-mapped bezier activation
// tracks the control points, predicts the curve value of every accepted item
// and compares the results in order, counting every mismatch
// ----------------------------------------------------------------------------
module tmba_curve_checker #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic signed [DATA_WIDTH-1:0]         x_value,
  input  logic                                 done,
  input  logic signed [DATA_WIDTH-1:0]         y_value,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [tmba_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]                cfg_data,
  output int                                   items_in_flight,
  output int                                   errors
);
  import tmba_pkg::*;

  localparam int FRAC = DATA_WIDTH - INT_BITS;
  localparam int SEG_SHIFT = FRAC - SEG_FRAC_DROP;

  // tanh(k/4) in q0.16
  localparam int TANH_Q16 [0:16] = '{
    0, 16051, 30285, 41625, 49913, 55593, 59320, 61694, 63179,
    64096, 64659, 65003, 65212, 65339, 65417, 65464, 65492
  };

  logic signed [DATA_WIDTH-1:0] curve_pts [0:3];
  logic signed [DATA_WIDTH-1:0] y_expected_q [$];
  logic signed [DATA_WIDTH-1:0] y_wanted;
  int                           error_count = 0;
  int                           result_num = 0;

  assign errors = error_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // a + floor((b - a) * t / 2^16)
  function automatic longint lerp_q16(input longint a, input longint b, input longint t);
    return a + (((b - a) * t) >>> 16);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] bezier_at_x(
    input logic signed [DATA_WIDTH-1:0] x
  );
    longint mag, seg, frac, th, t, lo, hi;
    longint a0, a1, a2, b0, b1, y;
    mag = (x < 0) ? -longint'(x) : longint'(x);
    seg = mag >> SEG_SHIFT;
    if (seg >= NUM_SEGS) begin
      th = TANH_Q16[NUM_SEGS];
    end else begin
      frac = mag & ((longint'(1) << SEG_SHIFT) - 1);
      lo = TANH_Q16[seg];
      hi = TANH_Q16[seg + 1];
      th = lo + (((hi - lo) * frac) >> SEG_SHIFT);
    end
    t = (x < 0) ? ((65536 - th) >> 1) : ((65536 + th) >> 1);
    a0 = lerp_q16(curve_pts[REG_POINT_ZERO], curve_pts[REG_POINT_ONE], t);
    a1 = lerp_q16(curve_pts[REG_POINT_ONE], curve_pts[REG_POINT_TWO], t);
    a2 = lerp_q16(curve_pts[REG_POINT_TWO], curve_pts[REG_POINT_THREE], t);
    b0 = lerp_q16(a0, a1, t);
    b1 = lerp_q16(a1, a2, t);
    y = lerp_q16(b0, b1, t);
    return y[DATA_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      curve_pts[REG_POINT_ZERO]  = '0;
      curve_pts[REG_POINT_ONE]   = DATA_WIDTH'(1 << FRAC);
      curve_pts[REG_POINT_TWO]   = DATA_WIDTH'(2 << FRAC);
      curve_pts[REG_POINT_THREE] = DATA_WIDTH'(3 << FRAC);
      y_expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_POINT_ZERO:  curve_pts[REG_POINT_ZERO]  = cfg_data;
          REG_POINT_ONE:   curve_pts[REG_POINT_ONE]   = cfg_data;
          REG_POINT_TWO:   curve_pts[REG_POINT_TWO]   = cfg_data;
          REG_POINT_THREE: curve_pts[REG_POINT_THREE] = cfg_data;
        endcase
      end
      if (done) begin
        if (y_expected_q.size() == 0) begin
          report_mismatch($sformatf("result y=%0d with no item waiting", y_value));
        end else begin
          y_wanted = y_expected_q.pop_front();
          if (y_value !== y_wanted)
            report_mismatch($sformatf("result %0d: y=%0d, expected %0d",
                                      result_num, y_value, y_wanted));
        end
        result_num++;
      end
      if (start && !busy)
        y_expected_q.push_back(bezier_at_x(x_value));
    end
    items_in_flight = y_expected_q.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the tanh-mapped bezier activation
// drives directed and random activation inputs under several control point
// settings, with random input gaps; a separate checker predicts and compares
// ----------------------------------------------------------------------------
module tb_top;
  import tmba_pkg::*;

  localparam int DATA_WIDTH = 16;
  localparam int RANDOM_ITEMS = 1750;
  localparam int RANDOM_PHASES = 10;
  // pipeline is five deep, give it some slack
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT = 400000;

  // boundaries of the tanh table segments, saturation and sign extremes
  localparam int EDGE_X [18] = '{
    0, 1, -1, 32767, -32768, 1023, 1024, -1024, -1025,
    4096, -4096, 16383, 16384, -16384, -16385, 21845, -21846, 2047
  };
  // short input set run under the extreme point settings
  localparam int EXTREME_X [3] = '{-32768, 0, 32767};

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic signed [DATA_WIDTH-1:0] x_value;
  logic                         done;
  logic signed [DATA_WIDTH-1:0] y_value;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]   cfg_index;
  logic [DATA_WIDTH-1:0]        cfg_data;

  int items_in_flight;
  int mismatch_count;
  int cycle_count = 0;

  tanh_mapped_bezier_activation #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .x_value  (x_value),
    .done     (done),
    .y_value  (y_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  tmba_curve_checker #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .x_value        (x_value),
    .done           (done),
    .y_value        (y_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .items_in_flight(items_in_flight),
    .errors         (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs or drops results
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one register write; valid stays high so back-to-back writes need no gap
  task automatic write_point(input cfg_reg_t reg_id, input logic [DATA_WIDTH-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_id;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all four points, starting at a random register so the write order varies
  task automatic load_points(input int p0, input int p1, input int p2, input int p3);
    int pts [4];
    int first;
    pts = '{p0, p1, p2, p3};
    first = $urandom_range(3);
    for (int i = 0; i < 4; i++)
      write_point(cfg_reg_t'((first + i) % 4), DATA_WIDTH'(pts[(first + i) % 4]));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one item and hold it until the block takes it
  task automatic send_x(input logic [DATA_WIDTH-1:0] x);
    @(negedge clk);
    start   <= 1'b1;
    x_value <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // sender gap of the given length, with junk on the data port
  task automatic hold_off(input int n);
    @(negedge clk);
    start   <= 1'b0;
    x_value <= DATA_WIDTH'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // wait for every expected result, then let the pipeline empty out
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (items_in_flight != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [DATA_WIDTH-1:0] pick_x;
    int sel;
    int v;
    sel = $urandom_range(7);
    case (sel)
      // whole input range, every bit pattern
      0, 1, 2: v = $urandom;
      // the curved part of tanh, within +-4.0
      3, 4: v = int'($urandom_range(32768)) - 16384;
      // around a segment boundary, either sign
      5, 6: begin
        v = int'($urandom_range(32) << 10) + int'($urandom_range(2)) - 1;
        if ($urandom_range(1)) v = -v;
      end
      // sign and saturation extremes
      default: v = EDGE_X[$urandom_range(4)];
    endcase
    return DATA_WIDTH'(v);
  endfunction

  function automatic int pick_point;
    case ($urandom_range(5))
      0: return -32768;
      1: return 32767;
      2, 3: return int'($urandom_range(32768)) - 16384;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // random items, with gap bursts now and then when idling is on
  task automatic run_random(input int count, input bit idling);
    for (int i = 0; i < count; i++) begin
      if (idling && $urandom_range(7) == 0)
        hold_off($urandom_range(1, 19));
      send_x(pick_x());
    end
  endtask

  initial begin
    // every input known from time zero
    rst       = 1'b1;
    start     = 1'b0;
    x_value   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_POINT_ZERO;
    cfg_data  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset points first: table edges, saturation, most negative input
    foreach (EDGE_X[i])
      send_x(DATA_WIDTH'(EDGE_X[i]));
    drain();

    // extreme point settings: flat at both ends, then zigzag both ways
    load_points(32767, 32767, 32767, 32767);
    foreach (EXTREME_X[i]) send_x(DATA_WIDTH'(EXTREME_X[i]));
    drain();
    load_points(-32768, -32768, -32768, -32768);
    foreach (EXTREME_X[i]) send_x(DATA_WIDTH'(EXTREME_X[i]));
    drain();
    load_points(-32768, 32767, -32768, 32767);
    foreach (EXTREME_X[i]) send_x(DATA_WIDTH'(EXTREME_X[i]));
    drain();
    load_points(32767, -32768, 32767, -32768);
    foreach (EXTREME_X[i]) send_x(DATA_WIDTH'(EXTREME_X[i]));
    drain();

    // random phases, a fresh point set for each; the last one runs flat out
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_points(pick_point(), pick_point(), pick_point(), pick_point());
      run_random(RANDOM_ITEMS / RANDOM_PHASES,
                 (ph < RANDOM_PHASES - 1) && ($urandom_range(3) != 0));
      drain();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> tanh_mapped_bezier_activation.f
hdl/tmba_pkg.sv
hdl/tmba_param_map.sv
hdl/tmba_lerp.sv
hdl/tanh_mapped_bezier_activation.sv
bench/tmba_curve_checker.sv
bench/tb_top.sv
